[rtl/core/mstm_pkg.sv]
package mstm_pkg;

   // Fixed sizes of the converter
   localparam int FRAME_BITS    = 48;
   localparam int MUS_CH_COUNT  = 16;
   localparam int MIDI_CH_COUNT = 16;
   localparam int NUMER_BITS    = 53;   // 32-bit ticks * 20-bit rate + 16-bit fraction
   localparam int DCNT_BITS     = $clog2(NUMER_BITS);

   // Result kinds
   localparam logic [1:0] KIND_MIDI  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_LOOP  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   // Error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_TRUNC     = 3'd1;
   localparam logic [2:0] ERR_BAD_VALUE = 3'd2;
   localparam logic [2:0] ERR_DELAY_OVF = 3'd3;
   localparam logic [2:0] ERR_NO_CHAN   = 3'd4;
   localparam logic [2:0] ERR_TIME_OVF  = 3'd5;
   localparam logic [2:0] ERR_ZERO_LOOP = 3'd6;
   localparam logic [2:0] ERR_NO_END    = 3'd7;

   // Register indexes
   localparam logic [1:0] CSR_FRAME_RATE  = 2'd0;
   localparam logic [1:0] CSR_TICK_RATE   = 2'd1;
   localparam logic [1:0] CSR_LOOP_ENABLE = 2'd2;
   localparam logic [1:0] CSR_FIRST_FRAME = 2'd3;

   // MIDI message types and fixed numbers
   localparam logic [3:0] ST_NOTE_OFF = 4'h8;
   localparam logic [3:0] ST_NOTE_ON  = 4'h9;
   localparam logic [3:0] ST_CTRL     = 4'hB;
   localparam logic [3:0] ST_PROG     = 4'hC;
   localparam logic [3:0] ST_BEND     = 4'hE;
   localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;
   localparam logic [3:0] PERC_MUS  = 4'd15;
   localparam logic [3:0] PERC_MIDI = 4'd9;

   typedef struct packed {
      logic [7:0] score_byte;
      logic       score_last;
   } req_type;

   typedef struct packed {
      logic [1:0]            result_kind;
      logic [7:0]            midi_status;
      logic [6:0]            midi_data_first;
      logic [6:0]            midi_data_second;
      logic [FRAME_BITS-1:0] frame_time;
      logic [2:0]            error_code;
      logic                  last_of_run;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic decode;
      logic mul;
      logic div_step;
      logic finish;
      logic emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_delay;
      logic div_last;
      logic emit_done;
   } sts_type;

   // MUS controller number to MIDI controller
   function automatic logic [6:0] ctrl_num(input logic [3:0] idx);
      logic [6:0] v;
      unique case (idx)
         4'd1:    v = 7'd32;
         4'd2:    v = 7'd1;
         4'd3:    v = 7'd7;
         4'd4:    v = 7'd10;
         4'd5:    v = 7'd11;
         4'd6:    v = 7'd91;
         4'd7:    v = 7'd93;
         4'd8:    v = 7'd64;
         4'd9:    v = 7'd67;
         default: v = 7'd0;
      endcase
      return v;
   endfunction

   // MUS system event (value minus 10) to MIDI controller
   function automatic logic [6:0] sys_num(input logic [2:0] idx);
      logic [6:0] v;
      unique case (idx)
         3'd0:    v = 7'd120;
         3'd1:    v = 7'd123;
         3'd2:    v = 7'd126;
         3'd3:    v = 7'd127;
         3'd4:    v = 7'd121;
         default: v = 7'd120;
      endcase
      return v;
   endfunction

endpackage

[rtl/core/mstm_ctrl.sv]
module mstm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mstm_pkg::sts_type sts,
   output mstm_pkg::cmd_type cmd
);
   import mstm_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_MUL    = 6'b000100,
      S_DIV    = 6'b001000,
      S_FINISH = 6'b010000,
      S_EMIT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_DECODE;
         S_DECODE: state_in = sts.need_delay ? S_MUL : S_EMIT;
         S_MUL:    state_in = S_DIV;
         S_DIV:    if (sts.div_last) state_in = S_FINISH;
         S_FINISH: state_in = S_EMIT;
         S_EMIT:   if (sts.emit_done) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // Commands
   assign req_stall    = (state_ff != S_IDLE);
   assign cmd.capture  = (state_ff == S_IDLE) & req_valid;
   assign cmd.decode   = (state_ff == S_DECODE);
   assign cmd.mul      = (state_ff == S_MUL);
   assign cmd.div_step = (state_ff == S_DIV);
   assign cmd.finish   = (state_ff == S_FINISH);
   assign cmd.emit     = (state_ff == S_EMIT);

endmodule

[rtl/core/mstm_dpath.sv]
module mstm_dpath (
   input  logic              clock,
   input  logic              reset,
   input  mstm_pkg::cmd_type cmd,
   output mstm_pkg::sts_type sts,
   input  mstm_pkg::req_type req_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [47:0]       csr_wdata,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mstm_pkg::rsp_type rsp_data
);
   import mstm_pkg::*;

   typedef enum logic [3:0] {
      PH_DESC  = 4'd0,
      PH_REL   = 4'd1,
      PH_NOTE  = 4'd2,
      PH_VEL   = 4'd3,
      PH_PITCH = 4'd4,
      PH_SYS   = 4'd5,
      PH_CNUM  = 4'd6,
      PH_CVAL  = 4'd7,
      PH_SKIP  = 4'd8,
      PH_DELAY = 4'd9
   } phase_type;

   localparam logic [FRAME_BITS-1:0] FRAME_START = '0;

   // Configuration
   logic [19:0] rate_ff;
   logic [15:0] tick_ff;
   logic        loop_en_ff;

   // Parser and song state
   req_type               in_ff;
   phase_type             ph_ff;
   logic [7:0]            desc_ff, op_ff;
   logic [31:0]           accum_ff;
   logic [2:0]            dcnt_ff;
   logic [4:0]            asg_ff [MUS_CH_COUNT];
   logic [6:0]            vel_ff [MUS_CH_COUNT];
   logic [4:0]            nf_ff;
   logic [FRAME_BITS-1:0] fc_ff;
   logic [15:0]           frac_ff;
   logic [31:0]           lt_ff;
   logic                  halted_ff;

   // Divider
   logic [NUMER_BITS-1:0] num_ff;
   logic [15:0]           rem_ff;
   logic [DCNT_BITS-1:0]  divc_ff;

   // Result slots and output register
   rsp_type    slot_ff [2];
   logic [1:0] scnt_ff, sidx_ff;
   rsp_type    rsp_ff;
   logic       rsp_valid_ff;

   function automatic rsp_type mk(input logic [1:0] kind, input logic [7:0] st,
                                  input logic [6:0] d1, input logic [6:0] d2,
                                  input logic [2:0] err, input logic [FRAME_BITS-1:0] fc);
      rsp_type r;
      r.result_kind      = kind;
      r.midi_status      = st;
      r.midi_data_first  = d1;
      r.midi_data_second = d2;
      r.frame_time       = fc;
      r.error_code       = err;
      r.last_of_run      = 1'b0;
      return r;
   endfunction

   // Byte decode: all state updates and results of one item
   phase_type  d_ph;
   logic [7:0] d_desc, d_op;
   logic [31:0] d_accum;
   logic [2:0] d_dcnt;
   logic       d_asg_we, d_vel_we, d_clr, d_halt, d_need;
   logic [4:0] d_asg_val, d_nf;
   logic [6:0] d_vel_val;
   logic [1:0] d_n;
   rsp_type    d_res [2];

   always_comb begin
      logic [7:0]  b;
      logic        fin, done, bad, endev, grp;
      logic [2:0]  typ;
      logic [3:0]  mch, ch;
      logic [4:0]  ch5;
      logic        ch_ok;
      logic [38:0] ext;
      logic [2:0]  cnt_nx;
      logic [6:0]  bv, vel;
      logic [7:0]  sysix;
      rsp_type     msg;

      b       = in_ff.score_byte;
      fin     = in_ff.score_last;
      done    = 1'b0;
      bad     = 1'b0;
      endev   = 1'b0;
      typ     = desc_ff[6:4];
      mch     = 4'd0;
      ch      = 4'd0;
      ch5     = 5'd0;
      ch_ok   = 1'b0;
      ext     = '0;
      cnt_nx  = 3'd0;
      bv      = 7'd0;
      vel     = 7'd0;
      sysix   = 8'd0;
      msg     = mk(KIND_MIDI, 8'd0, 7'd0, 7'd0, ERR_NONE, fc_ff);
      grp     = 1'b0;

      d_ph      = ph_ff;
      d_desc    = desc_ff;
      d_op      = op_ff;
      d_accum   = accum_ff;
      d_dcnt    = dcnt_ff;
      d_asg_we  = 1'b0;
      d_asg_val = 5'd0;
      d_vel_we  = 1'b0;
      d_vel_val = b[6:0];
      d_nf      = nf_ff;
      d_clr     = 1'b0;
      d_halt    = 1'b0;
      d_need    = 1'b0;
      d_n       = 2'd0;
      d_res[0]  = mk(KIND_MIDI, 8'd0, 7'd0, 7'd0, ERR_NONE, fc_ff);
      d_res[1]  = d_res[0];

      if (!halted_ff) begin
         // Phase handling
         unique case (ph_ff)
            PH_DESC: begin
               d_desc = b;
               typ    = b[6:4];
               unique case (b[6:4])
                  3'd0: d_ph = PH_REL;
                  3'd1: d_ph = PH_NOTE;
                  3'd2: d_ph = PH_PITCH;
                  3'd3: d_ph = PH_SYS;
                  3'd4: d_ph = PH_CNUM;
                  3'd5: done = 1'b1;
                  3'd6: begin
                     // End of score
                     endev = 1'b1;
                     if (!loop_en_ff) begin
                        d_halt   = 1'b1;
                        d_res[0] = mk(KIND_DONE, 8'd0, 7'd0, 7'd0, ERR_NONE, fc_ff);
                     end else if (lt_ff == 32'd0) begin
                        d_halt   = 1'b1;
                        d_res[0] = mk(KIND_ERROR, 8'd0, 7'd0, 7'd0, ERR_ZERO_LOOP, fc_ff);
                     end else begin
                        d_clr    = 1'b1;
                        d_nf     = 5'd0;
                        d_ph     = PH_DESC;
                        d_res[0] = mk(KIND_LOOP, 8'd0, 7'd0, 7'd0, ERR_NONE, fc_ff);
                     end
                     d_n = 2'd1;
                  end
                  default: d_ph = PH_SKIP;
               endcase
            end
            PH_REL, PH_PITCH: begin
               d_op = b;
               done = 1'b1;
            end
            PH_NOTE: begin
               d_op = {1'b0, b[6:0]};
               if (b[7]) d_ph = PH_VEL;
               else      done = 1'b1;
            end
            PH_VEL: begin
               d_vel_we = 1'b1;
               done     = 1'b1;
            end
            PH_SYS: begin
               d_op = b;
               bad  = (b < 8'd10) || (b > 8'd14);
               done = 1'b1;
            end
            PH_CNUM: begin
               d_op = b;
               d_ph = PH_CVAL;
            end
            PH_CVAL: begin
               bad  = (op_ff > 8'd9);
               done = 1'b1;
            end
            PH_SKIP: done = 1'b1;
            PH_DELAY: begin
               // One base-128 delay digit
               ext = {accum_ff, 7'd0} + {32'd0, b[6:0]};
               if (ext[38:32] != 7'd0) begin
                  d_halt   = 1'b1;
                  d_res[0] = mk(KIND_ERROR, 8'd0, 7'd0, 7'd0, ERR_DELAY_OVF, fc_ff);
                  d_n      = 2'd1;
               end else begin
                  cnt_nx  = dcnt_ff + 3'd1;
                  d_accum = ext[31:0];
                  d_dcnt  = cnt_nx;
                  if (b[7]) begin
                     if (cnt_nx >= 3'd5) begin
                        d_halt   = 1'b1;
                        d_res[0] = mk(KIND_ERROR, 8'd0, 7'd0, 7'd0, ERR_DELAY_OVF, fc_ff);
                        d_n      = 2'd1;
                     end else if (fin) begin
                        d_halt   = 1'b1;
                        d_res[0] = mk(KIND_ERROR, 8'd0, 7'd0, 7'd0, ERR_TRUNC, fc_ff);
                        d_n      = 2'd1;
                     end
                  end else if (fin) begin
                     d_halt   = 1'b1;
                     d_res[0] = mk(KIND_ERROR, 8'd0, 7'd0, 7'd0, ERR_NO_END, fc_ff);
                     d_n      = 2'd1;
                  end else begin
                     d_ph   = PH_DESC;
                     d_need = 1'b1;
                  end
               end
            end
            default: ;
         endcase

         // Event completion
         if (ph_ff != PH_DELAY && !endev) begin
            grp = d_desc[7];
            if (bad) begin
               d_halt   = 1'b1;
               d_res[0] = mk(KIND_ERROR, 8'd0, 7'd0, 7'd0, ERR_BAD_VALUE, fc_ff);
               d_n      = 2'd1;
            end else if (!done) begin
               if (fin) begin
                  d_halt   = 1'b1;
                  d_res[0] = mk(KIND_ERROR, 8'd0, 7'd0, 7'd0, ERR_TRUNC, fc_ff);
                  d_n      = 2'd1;
               end
            end else if (fin) begin
               d_halt   = 1'b1;
               d_res[0] = mk(KIND_ERROR, 8'd0, 7'd0, 7'd0,
                             grp ? ERR_TRUNC : ERR_NO_END, fc_ff);
               d_n      = 2'd1;
            end else begin
               if (grp) begin
                  d_ph    = PH_DELAY;
                  d_accum = 32'd0;
                  d_dcnt  = 3'd0;
               end else begin
                  d_ph = PH_DESC;
               end
               if (typ <= 3'd4) begin
                  // Channel mapping
                  mch = d_desc[3:0];
                  if (mch == PERC_MUS) begin
                     ch    = PERC_MIDI;
                     ch_ok = 1'b1;
                  end else if (asg_ff[mch][4]) begin
                     ch    = asg_ff[mch][3:0];
                     ch_ok = 1'b1;
                  end else begin
                     ch5 = (nf_ff == {1'b0, PERC_MIDI}) ? nf_ff + 5'd1 : nf_ff;
                     if (ch5 >= 5'(MIDI_CH_COUNT)) begin
                        d_halt   = 1'b1;
                        d_res[0] = mk(KIND_ERROR, 8'd0, 7'd0, 7'd0, ERR_NO_CHAN, fc_ff);
                        d_n      = 2'd1;
                     end else begin
                        ch        = ch5[3:0];
                        ch_ok     = 1'b1;
                        d_asg_we  = 1'b1;
                        d_asg_val = {1'b1, ch5[3:0]};
                        d_nf      = ch5 + 5'd1;
                        d_res[0]  = mk(KIND_MIDI, {ST_CTRL, ch5[3:0]}, CC_ALL_NOTES_OFF,
                                       7'd0, ERR_NONE, fc_ff);
                        d_n       = 2'd1;
                     end
                  end
                  // Event message
                  if (ch_ok) begin
                     vel   = (ph_ff == PH_VEL) ? b[6:0] : vel_ff[mch];
                     bv    = b[7] ? 7'd127 : b[6:0];
                     sysix = d_op - 8'd10;
                     unique case (typ)
                        3'd0: msg = mk(KIND_MIDI, {ST_NOTE_OFF, ch}, d_op[6:0], 7'd0,
                                       ERR_NONE, fc_ff);
                        3'd1: msg = mk(KIND_MIDI, {ST_NOTE_ON, ch}, d_op[6:0], vel,
                                       ERR_NONE, fc_ff);
                        3'd2: msg = mk(KIND_MIDI, {ST_BEND, ch}, {d_op[0], 6'd0},
                                       d_op[7:1], ERR_NONE, fc_ff);
                        3'd3: msg = mk(KIND_MIDI, {ST_CTRL, ch}, sys_num(sysix[2:0]),
                                       7'd0, ERR_NONE, fc_ff);
                        default: begin
                           if (d_op == 8'd0)
                              msg = mk(KIND_MIDI, {ST_PROG, ch}, bv, 7'd0, ERR_NONE, fc_ff);
                           else
                              msg = mk(KIND_MIDI, {ST_CTRL, ch}, ctrl_num(d_op[3:0]), bv,
                                       ERR_NONE, fc_ff);
                        end
                     endcase
                     if (d_n == 2'd0) begin
                        d_res[0] = msg;
                        d_n      = 2'd1;
                     end else begin
                        d_res[1] = msg;
                        d_n      = 2'd2;
                     end
                  end
               end
            end
         end
      end

      // Mark the final result of the item
      if (d_n == 2'd1) d_res[0].last_of_run = 1'b1;
      if (d_n == 2'd2) d_res[1].last_of_run = 1'b1;
   end

   // Delay scaling: product, divide step, final update
   logic [51:0]           prod;
   logic [15:0]           dvs;
   logic [16:0]           rem_sh;
   logic                  ge;
   logic [53:0]           fsum;
   logic [32:0]           lsum;
   logic                  f_ovf, l_ovf;
   logic [FRAME_BITS-1:0] fc_new;
   rsp_type               tovf_res;

   assign prod   = accum_ff * rate_ff;
   assign dvs    = (tick_ff == 16'd0) ? 16'd1 : tick_ff;
   assign rem_sh = {rem_ff, num_ff[NUMER_BITS-1]};
   assign ge     = (rem_sh >= {1'b0, dvs});
   assign fsum   = {6'd0, fc_ff} + {1'b0, num_ff};
   assign f_ovf  = (fsum[53:FRAME_BITS] != '0);
   assign fc_new = fsum[FRAME_BITS-1:0];
   assign lsum   = {1'b0, lt_ff} + {1'b0, accum_ff};
   assign l_ovf  = lsum[32];

   // Time overflow result, the only result of its item
   always_comb begin
      tovf_res = mk(KIND_ERROR, 8'd0, 7'd0, 7'd0, ERR_TIME_OVF, f_ovf ? fc_ff : fc_new);
      tovf_res.last_of_run = 1'b1;
   end

   // Status to controller
   assign sts.need_delay = d_need;
   assign sts.div_last   = (divc_ff == DCNT_BITS'(NUMER_BITS - 1));
   assign sts.emit_done  = (sidx_ff == scnt_ff);

   // Control and song state
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff    <= 20'd44100;
         tick_ff    <= 16'd140;
         loop_en_ff <= 1'b0;
         ph_ff      <= PH_DESC;
         desc_ff    <= 8'd0;
         op_ff      <= 8'd0;
         accum_ff   <= 32'd0;
         dcnt_ff    <= 3'd0;
         nf_ff      <= 5'd0;
         fc_ff      <= FRAME_START;
         frac_ff    <= 16'd0;
         lt_ff      <= 32'd0;
         halted_ff  <= 1'b0;
         scnt_ff    <= 2'd0;
         sidx_ff    <= 2'd0;
         for (int i = 0; i < MUS_CH_COUNT; i++) begin
            asg_ff[i] <= 5'd0;
            vel_ff[i] <= 7'd127;
         end
      end else begin
         // Register writes
         if (csr_we) begin
            unique case (csr_index)
               CSR_FRAME_RATE:  rate_ff    <= csr_wdata[19:0];
               CSR_TICK_RATE:   tick_ff    <= csr_wdata[15:0];
               CSR_LOOP_ENABLE: loop_en_ff <= csr_wdata[0];
               CSR_FIRST_FRAME: fc_ff      <= csr_wdata[FRAME_BITS-1:0];
               default: ;
            endcase
         end
         // Commit decode
         if (cmd.decode) begin
            ph_ff     <= d_ph;
            desc_ff   <= d_desc;
            op_ff     <= d_op;
            accum_ff  <= d_accum;
            dcnt_ff   <= d_dcnt;
            nf_ff     <= d_nf;
            halted_ff <= halted_ff | d_halt;
            scnt_ff   <= d_n;
            sidx_ff   <= 2'd0;
            if (d_asg_we) asg_ff[d_desc[3:0]] <= d_asg_val;
            if (d_vel_we) vel_ff[d_desc[3:0]] <= d_vel_val;
            if (d_clr) begin
               lt_ff <= 32'd0;
               for (int i = 0; i < MUS_CH_COUNT; i++) begin
                  asg_ff[i] <= 5'd0;
                  vel_ff[i] <= 7'd127;
               end
            end
         end
         // Apply the scaled delay
         if (cmd.finish) begin
            frac_ff <= rem_ff;
            if (f_ovf) begin
               halted_ff <= 1'b1;
               scnt_ff   <= 2'd1;
            end else begin
               fc_ff <= fc_new;
               if (l_ovf) begin
                  halted_ff <= 1'b1;
                  scnt_ff   <= 2'd1;
               end else begin
                  lt_ff <= lsum[31:0];
               end
            end
         end
         if (cmd.emit && sidx_ff != scnt_ff && (!rsp_valid_ff || !rsp_stall))
            sidx_ff <= sidx_ff + 2'd1;
      end
   end

   // Payload registers: input byte, divider, result slots
   always_ff @(posedge clock) begin
      if (cmd.capture) in_ff <= req_data;
      if (cmd.mul) begin
         num_ff  <= {1'b0, prod} + {37'd0, frac_ff};
         rem_ff  <= 16'd0;
         divc_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff  <= {num_ff[NUMER_BITS-2:0], ge};
         rem_ff  <= ge ? 16'(rem_sh - {1'b0, dvs}) : rem_sh[15:0];
         divc_ff <= divc_ff + DCNT_BITS'(1);
      end
      if (cmd.decode) begin
         slot_ff[0] <= d_res[0];
         slot_ff[1] <= d_res[1];
      end else if (cmd.finish) begin
         slot_ff[0] <= tovf_res;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit && sidx_ff != scnt_ff && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit && sidx_ff != scnt_ff && (!rsp_valid_ff || !rsp_stall))
         rsp_ff <= slot_ff[sidx_ff[0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/core/mus_score_to_midi_converter_core.sv]
// MUS score to MIDI converter. Score bytes enter one item at a time on req_*; each byte
// gives zero to two results on rsp_* (MIDI message, song finished, loop restart or error),
// each stamped with the output frame. For a byte that ends a group delay, the delay is
// scaled by one 32x20 multiply and then a 53-step bit-serial divide by tick_rate (by 1
// when tick_rate is zero) before any result goes out. A stalled output holds the results
// back and keeps further bytes out. After an error or a finished song the block drops all
// bytes until reset. Registers are written on csr_*: 0 frame rate, 1 tick_rate,
// 2 loop_enable, 3 first frame (also loads the frame clock); write them only while the
// block is idle.
module mus_score_to_midi_converter_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mstm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mstm_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [47:0]       csr_wdata
);
   import mstm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mstm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mstm_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // One item in flight at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while an item is in work");

   // Error codes only on error results
   a_err_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind != KIND_ERROR) |-> rsp_data.error_code == ERR_NONE)
      else $error("error code on a non-error result");

   // Non-MIDI results carry no message
   a_msg_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind != KIND_MIDI) |-> rsp_data.midi_status == 8'd0)
      else $error("MIDI status on a non-MIDI result");

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
   import mstm_pkg::*;

   localparam logic [47:0] FRAME_MAX  = 48'hFFFF_FFFF_FFFF;
   localparam int          STALL_LIMIT = 5000;
   localparam int          SETTLE      = 100;

   typedef enum logic [3:0] {
      P_DESC, P_REL, P_NOTE, P_VEL, P_PITCH, P_SYS, P_CNUM, P_CVAL, P_SKIP, P_DELAY
   } parse_phase_type;

   // shadow of the converter state
   typedef struct {
      parse_phase_type phase;
      logic [7:0]   desc;
      logic [7:0]   oper;
      logic [31:0]  acc;
      logic [2:0]   dcnt;
      logic [4:0]   asg [16];
      logic [6:0]   vel [16];
      logic [4:0]   next_ch;
      logic [47:0]  fclk;
      logic [31:0]  frac;
      logic [31:0]  lticks;
      logic         halted;
   } conv_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = CSR_FRAME_RATE;
   logic [47:0] csr_wdata = '0;

   // configuration copy
   logic [19:0] rate_cfg = 20'd44100;
   logic [15:0] tick_cfg = 16'd140;
   logic        loop_cfg = 1'b0;

   conv_state_type score_st;
   req_type     pending_bytes [$];
   rsp_type     midi_expected [$];
   rsp_type     step_out [$];
   int          errors = 0;
   int          quiet_cycles = 0;
   int          send_gap = 0;
   int          stall_left = 0;
   bit          no_idle = 0;

   const logic [6:0] ctl_cc [10] = '{7'd0, 7'd32, 7'd1, 7'd7, 7'd10, 7'd11,
                                     7'd91, 7'd93, 7'd64, 7'd67};
   const logic [6:0] sys_cc [5]  = '{7'd120, 7'd123, 7'd126, 7'd127, 7'd121};

   // directed score: every event kind, value edges, a five-byte delay, loop restart
   const logic [7:0] demo_bytes [28] = '{8'h10, 8'hBC, 8'h7F, 8'h01, 8'h00, 8'h22, 8'hFF,
                                         8'h33, 8'h0A, 8'h33, 8'h0E, 8'h44, 8'h00, 8'h55,
                                         8'h44, 8'h09, 8'h80, 8'h5F, 8'h7F, 8'hAA, 8'h9F,
                                         8'h23, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h60};

   mus_score_to_midi_converter_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report(input string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic void clear_map(inout conv_state_type s);
      for (int i = 0; i < 16; i++) begin
         s.asg[i] = '0;
         s.vel[i] = 7'd127;
      end
      s.next_ch = '0;
   endfunction

   function automatic void post(inout conv_state_type s, input logic [1:0] kind,
                                input logic [7:0] status, input logic [6:0] d1,
                                input logic [6:0] d2, input logic [2:0] err);
      rsp_type r;
      if (step_out.size() >= 2) return;
      r = '{kind, status, d1, d2, s.fclk, err, 1'b0};
      step_out.push_back(r);
   endfunction

   function automatic void raise(inout conv_state_type s, input logic [2:0] err);
      s.halted = 1'b1;
      post(s, KIND_ERROR, 8'd0, 7'd0, 7'd0, err);
   endfunction

   // scale a group delay onto the frame clock; 0 on overflow
   function automatic bit advance_frames(inout conv_state_type s, input logic [31:0] ticks);
      logic [63:0] div, numer, delta;
      div = (tick_cfg == 0) ? 64'd1 : {48'd0, tick_cfg};
      numer = {32'd0, ticks} * {44'd0, rate_cfg} + {32'd0, s.frac};
      delta = numer / div;
      s.frac = 32'(numer % div);
      if (delta > {16'd0, FRAME_MAX - s.fclk}) return 0;
      s.fclk = s.fclk + delta[47:0];
      if (32'hFFFF_FFFF - s.lticks < ticks) return 0;
      s.lticks = s.lticks + ticks;
      return 1;
   endfunction

   // one score byte through the converter; results land in step_out
   function automatic void score_step(inout conv_state_type s, input logic [7:0] b,
                                      input logic fin);
      logic        done, bad, gend;
      logic [2:0]  ek;
      logic [6:0]  low, v2;
      logic [3:0]  mch;
      logic [4:0]  ch;
      logic [7:0]  a;
      step_out.delete();
      if (s.halted) return;
      done = 0;
      bad = 0;
      ek = s.desc[6:4];
      case (s.phase)
         P_DESC: begin
            s.desc = b;
            ek = b[6:4];
            case (ek)
               3'd0: s.phase = P_REL;
               3'd1: s.phase = P_NOTE;
               3'd2: s.phase = P_PITCH;
               3'd3: s.phase = P_SYS;
               3'd4: s.phase = P_CNUM;
               3'd5: done = 1;
               3'd6: begin
                  if (!loop_cfg) begin
                     s.halted = 1'b1;
                     post(s, KIND_DONE, 8'd0, 7'd0, 7'd0, ERR_NONE);
                  end else if (s.lticks == 0) begin
                     raise(s, ERR_ZERO_LOOP);
                  end else begin
                     clear_map(s);
                     s.lticks = '0;
                     s.phase = P_DESC;
                     post(s, KIND_LOOP, 8'd0, 7'd0, 7'd0, ERR_NONE);
                  end
                  step_out[step_out.size()-1].last_of_run = 1'b1;
                  return;
               end
               default: s.phase = P_SKIP;
            endcase
         end
         P_REL, P_PITCH: begin
            s.oper = b;
            done = 1;
         end
         P_NOTE: begin
            s.oper = {1'b0, b[6:0]};
            if (b[7]) s.phase = P_VEL;
            else done = 1;
         end
         P_VEL: begin
            s.vel[s.desc[3:0]] = b[6:0];
            done = 1;
         end
         P_SYS: begin
            s.oper = b;
            bad = (b < 8'd10 || b > 8'd14);
            done = 1;
         end
         P_CNUM: begin
            s.oper = b;
            s.phase = P_CVAL;
         end
         P_CVAL: begin
            bad = s.oper > 8'd9;
            done = 1;
         end
         P_SKIP: done = 1;
         default: begin
            low = b[6:0];
            if (s.acc > (32'hFFFF_FFFF - {25'd0, low}) / 32'd128) begin
               raise(s, ERR_DELAY_OVF);
            end else begin
               s.acc = s.acc * 32'd128 + {25'd0, low};
               s.dcnt = s.dcnt + 3'd1;
               if (b[7]) begin
                  if (s.dcnt >= 3'd5) raise(s, ERR_DELAY_OVF);
                  else if (fin) raise(s, ERR_TRUNC);
               end else if (fin) begin
                  raise(s, ERR_NO_END);
               end else begin
                  s.phase = P_DESC;
                  if (!advance_frames(s, s.acc)) raise(s, ERR_TIME_OVF);
               end
            end
         end
      endcase

      if (!s.halted && s.phase != P_DELAY) begin
         gend = s.desc[7];
         if (bad) begin
            raise(s, ERR_BAD_VALUE);
         end else if (!done) begin
            if (fin) raise(s, ERR_TRUNC);
         end else if (fin) begin
            raise(s, gend ? ERR_TRUNC : ERR_NO_END);
         end else begin
            // playable event: map the channel, then the message itself
            if (ek != 3'd5 && ek != 3'd7) begin
               mch = s.desc[3:0];
               a = s.oper;
               ch = 5'd16;
               if (mch == PERC_MUS) begin
                  ch = {1'b0, PERC_MIDI};
               end else if (s.asg[mch][4]) begin
                  ch = {1'b0, s.asg[mch][3:0]};
               end else begin
                  ch = s.next_ch;
                  if (ch == {1'b0, PERC_MIDI}) ch = ch + 5'd1;
                  if (ch >= 5'd16) begin
                     raise(s, ERR_NO_CHAN);
                  end else begin
                     s.asg[mch] = {1'b1, ch[3:0]};
                     s.next_ch = ch + 5'd1;
                     post(s, KIND_MIDI, {ST_CTRL, ch[3:0]}, CC_ALL_NOTES_OFF, 7'd0, ERR_NONE);
                  end
               end
               if (!s.halted) begin
                  case (ek)
                     3'd0: post(s, KIND_MIDI, {ST_NOTE_OFF, ch[3:0]}, a[6:0], 7'd0, ERR_NONE);
                     3'd1: post(s, KIND_MIDI, {ST_NOTE_ON, ch[3:0]}, a[6:0], s.vel[mch],
                                ERR_NONE);
                     3'd2: post(s, KIND_MIDI, {ST_BEND, ch[3:0]}, {a[0], 6'd0}, a[7:1],
                                ERR_NONE);
                     3'd3: post(s, KIND_MIDI, {ST_CTRL, ch[3:0]}, sys_cc[(a - 8'd10) % 5],
                                7'd0, ERR_NONE);
                     default: begin
                        v2 = b[7] ? 7'd127 : b[6:0];
                        if (a == 0)
                           post(s, KIND_MIDI, {ST_PROG, ch[3:0]}, v2, 7'd0, ERR_NONE);
                        else
                           post(s, KIND_MIDI, {ST_CTRL, ch[3:0]}, ctl_cc[a % 10], v2,
                                ERR_NONE);
                     end
                  endcase
               end
            end
            if (gend) begin
               s.phase = P_DELAY;
               s.acc = '0;
               s.dcnt = '0;
            end else begin
               s.phase = P_DESC;
            end
         end
      end
      if (step_out.size() > 0) step_out[step_out.size()-1].last_of_run = 1'b1;
   endfunction

   // well-formed byte for the current parse phase, with a little noise
   function automatic logic [7:0] pick_byte(input conv_state_type s);
      int r;
      logic [2:0] ek;
      r = $urandom_range(0, 99);
      case (s.phase)
         P_DESC: begin
            ek = (r < 4) ? 3'd6 : (r < 10) ? 3'd5 : (r < 15) ? 3'd7 : 3'($urandom_range(0, 4));
            return {($urandom_range(0, 2) == 0), ek, 4'($urandom_range(0, 15))};
         end
         P_SYS:   return (r < 90) ? 8'($urandom_range(10, 14)) : 8'($urandom);
         P_CNUM:  return (r < 90) ? 8'($urandom_range(0, 9)) : 8'($urandom);
         P_DELAY: begin
            if (r < 3) return 8'($urandom);
            if (s.dcnt == 0 && r < 33) return {1'b1, 7'($urandom)};
            return {1'b0, 7'($urandom)};
         end
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic queue_byte(input logic [7:0] b, input logic fin);
      req_type it;
      score_step(score_st, b, fin);
      foreach (step_out[i]) midi_expected.push_back(step_out[i]);
      it.score_byte = b;
      it.score_last = fin;
      pending_bytes.push_back(it);
   endtask

   // random byte that keeps the song running where one can be found
   task automatic queue_random;
      conv_state_type trial;
      logic [7:0] b;
      for (int t = 0; t < 200; t++) begin
         b = pick_byte(score_st);
         trial = score_st;
         score_step(trial, b, 1'b0);
         if (!trial.halted) break;
      end
      queue_byte(b, 1'b0);
   endtask

   task automatic wait_idle;
      while (pending_bytes.size() != 0 || midi_expected.size() != 0 || req_valid)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_FRAME_RATE:  rate_cfg = val[19:0];
         CSR_TICK_RATE:   tick_cfg = val[15:0];
         CSR_LOOP_ENABLE: loop_cfg = val[0];
         default:         score_st.fclk = val;
      endcase
   endtask

   task automatic configure(input logic [19:0] rate, input logic [15:0] tick,
                            input logic lp, input logic [47:0] start);
      write_reg(CSR_FRAME_RATE, {28'd0, rate});
      write_reg(CSR_TICK_RATE, {32'd0, tick});
      write_reg(CSR_LOOP_ENABLE, {47'd0, lp});
      write_reg(CSR_FIRST_FRAME, start);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // sender: bytes from the pending queue with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_data <= pending_bytes.pop_front();
            req_valid <= 1'b1;
            if (no_idle || $urandom_range(0, 1)) send_gap <= 0;
            else if ($urandom_range(0, 9) != 0) send_gap <= $urandom_range(1, 3);
            else send_gap <= $urandom_range(10, 60);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall and result check
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (midi_expected.size() == 0) begin
               report($sformatf("unexpected result %h", rsp_data));
            end else begin
               want = midi_expected.pop_front();
               if (rsp_data.result_kind != want.result_kind)
                  report($sformatf("result_kind %0d want %0d", rsp_data.result_kind,
                                   want.result_kind));
               if (rsp_data.midi_status != want.midi_status)
                  report($sformatf("midi_status %h want %h", rsp_data.midi_status,
                                   want.midi_status));
               if (rsp_data.midi_data_first != want.midi_data_first)
                  report($sformatf("midi_data_first %0d want %0d", rsp_data.midi_data_first,
                                   want.midi_data_first));
               if (rsp_data.midi_data_second != want.midi_data_second)
                  report($sformatf("midi_data_second %0d want %0d",
                                   rsp_data.midi_data_second, want.midi_data_second));
               if (rsp_data.frame_time != want.frame_time)
                  report($sformatf("frame_time %0d want %0d", rsp_data.frame_time,
                                   want.frame_time));
               if (rsp_data.error_code != want.error_code)
                  report($sformatf("error_code %0d want %0d", rsp_data.error_code,
                                   want.error_code));
               if (rsp_data.last_of_run != want.last_of_run)
                  report($sformatf("last_of_run %0d want %0d", rsp_data.last_of_run,
                                   want.last_of_run));
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (no_idle || $urandom_range(0, 1)) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b1;
            stall_left <= ($urandom_range(0, 9) != 0) ? $urandom_range(0, 3)
                                                      : $urandom_range(10, 60);
         end
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      score_st.phase = P_DESC;
      score_st.desc = '0;
      score_st.oper = '0;
      score_st.acc = '0;
      score_st.dcnt = '0;
      score_st.fclk = '0;
      score_st.frac = '0;
      score_st.lticks = '0;
      score_st.halted = 1'b0;
      clear_map(score_st);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: every event kind, value edges, a five-byte delay, loop restart
      write_reg(CSR_LOOP_ENABLE, 48'd1);
      @(posedge clock);
      csr_we <= 1'b0;
      foreach (demo_bytes[i])
         queue_byte(demo_bytes[i], 1'b0);

      // random phases under different register settings
      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         no_idle = ($urandom_range(0, 3) == 0);
         case (ph)
            0: configure(20'd1, 16'hFFFF, 1'b1, 48'd0);
            1: configure(20'hFFFFF, 16'd1, 1'b1, 48'($urandom));
            2: configure(20'($urandom), 16'($urandom_range(1, 65535)), 1'b0,
                         FRAME_MAX - 48'h100_0000_0000);
            default: configure(20'($urandom_range(1, 1048575)),
                               16'($urandom_range(1, 65535)), 1'($urandom),
                               {6'd0, 42'($urandom) << 10});
         endcase
         repeat (200) queue_random();
      end

      // finale: a closing byte flagged last, then random bytes that the block drops if it has halted
      wait_idle();
      configure(20'($urandom_range(1, 1048575)), 16'($urandom_range(1, 65535)),
                1'($urandom), FRAME_MAX - 48'($urandom_range(0, 1000)));
      queue_byte(pick_byte(score_st), 1'b1);
      repeat (3) queue_byte(8'($urandom), 1'($urandom));
      wait_idle();
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
